/* rtl/apr_pkg.sv */
`default_nettype none

package apr_pkg;

	// Default buffer depth (inner positions kept at once)
	localparam int MAX_INNER_DEF = 1024;

	// Output queue depth; a power of two
	localparam int OFIFO_DEPTH = 4;

	// Buffer word: overflow bit over the 32-bit partial product
	localparam int MEM_W = 33;

	// Upper bound of outer_count and reduce_length
	localparam logic [20:0] AXIS_MAX = 21'd1048576;

	// Configuration register indexes
	localparam logic [1:0] CFG_OUTER = 2'd0;
	localparam logic [1:0] CFG_REDUCE = 2'd1;
	localparam logic [1:0] CFG_INNER = 2'd2;

	// Address width for a given depth, never zero
	function automatic int addr_w(input int depth);
		addr_w = (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Per-element control from the sequencer
	typedef struct packed {
		logic        first;
		logic        emit;
		logic        last;
		logic [29:0] pos;
	} ctl_t;

	// One result word
	typedef struct packed {
		logic signed [31:0] product_value;
		logic [29:0]        position_index;
		logic               product_overflow;
		logic               tensor_overflow;
		logic               last_of_tensor;
	} out_item_t;

endpackage

`default_nettype wire

/* rtl/apr_mem.sv */
`default_nettype none

module apr_mem #(
	parameter int DEPTH = apr_pkg::MAX_INNER_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [apr_pkg::addr_w(DEPTH)-1:0]      waddr,
	input  wire logic [apr_pkg::MEM_W-1:0]              wdata,
	input  wire logic                                   re,
	input  wire logic [apr_pkg::addr_w(DEPTH)-1:0]      raddr,
	output      logic [apr_pkg::MEM_W-1:0]              rdata
);

	logic [apr_pkg::MEM_W-1:0] mem [DEPTH];

	// Write the updated partial
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, held while no element enters
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/apr_ofifo.sv */
`default_nettype none

module apr_ofifo (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    push,
	input  wire apr_pkg::out_item_t                      push_item,
	input  wire logic                                    pop,
	output      logic                                    not_empty,
	output      apr_pkg::out_item_t                      head,
	output      logic [$clog2(apr_pkg::OFIFO_DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(apr_pkg::OFIFO_DEPTH);
	localparam int CW = $clog2(apr_pkg::OFIFO_DEPTH + 1);

	apr_pkg::out_item_t slot_q [apr_pkg::OFIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != '0);

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];
	assign count     = count_q;

endmodule

`default_nettype wire

/* rtl/apr_seq.sv */
`default_nettype none

module apr_seq #(
	parameter int MAX_INNER = apr_pkg::MAX_INNER_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_wr,
	input  wire logic [1:0]                            cfg_index,
	input  wire logic [31:0]                           cfg_data,
	input  wire logic                                  advance,
	output      logic [apr_pkg::addr_w(MAX_INNER)-1:0] ip,
	output      apr_pkg::ctl_t                         ctl
);

	localparam int AW = apr_pkg::addr_w(MAX_INNER);

	logic [19:0] ocnt_m1_q;
	logic [19:0] rlen_m1_q;
	logic [10:0] icnt_q;
	logic [10:0] icnt_m1_q;
	logic [AW-1:0] inner_q;
	logic [19:0] axis_q;
	logic [19:0] outer_q;
	logic [29:0] base_q;

	logic [20:0] v_outer;
	logic [20:0] v_reduce;
	logic [10:0] v_inner;
	logic [20:0] c_outer;
	logic [20:0] c_reduce;
	logic [10:0] c_inner;
	logic        inner_end;
	logic        axis_end;
	logic        outer_end;

	// Clamp written values: zero acts as one, saturate above range
	always_comb begin
		v_outer  = cfg_data[20:0];
		v_reduce = cfg_data[20:0];
		v_inner  = cfg_data[10:0];
		if (v_outer == '0) begin
			c_outer = 21'd1;
		end else if (v_outer > apr_pkg::AXIS_MAX) begin
			c_outer = apr_pkg::AXIS_MAX;
		end else begin
			c_outer = v_outer;
		end
		if (v_reduce == '0) begin
			c_reduce = 21'd1;
		end else if (v_reduce > apr_pkg::AXIS_MAX) begin
			c_reduce = apr_pkg::AXIS_MAX;
		end else begin
			c_reduce = v_reduce;
		end
		if (v_inner == '0) begin
			c_inner = 11'd1;
		end else if (32'(v_inner) > MAX_INNER) begin
			c_inner = 11'(MAX_INNER);
		end else begin
			c_inner = v_inner;
		end
	end

	assign inner_end = (32'(inner_q) == 32'(icnt_m1_q));
	assign axis_end  = (axis_q == rlen_m1_q);
	assign outer_end = (outer_q == ocnt_m1_q);

	assign ip        = inner_q;
	assign ctl.first = (axis_q == '0);
	assign ctl.emit  = axis_end;
	assign ctl.last  = axis_end && inner_end && outer_end;
	assign ctl.pos   = base_q + 30'(inner_q);

	// Take register writes; restart the tensor on any write to a known index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_m1_q <= '0;
			rlen_m1_q <= '0;
			icnt_q    <= 11'd1;
			icnt_m1_q <= '0;
			inner_q   <= '0;
			axis_q    <= '0;
			outer_q   <= '0;
			base_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				apr_pkg::CFG_OUTER:  ocnt_m1_q <= 20'(c_outer - 21'd1);
				apr_pkg::CFG_REDUCE: rlen_m1_q <= 20'(c_reduce - 21'd1);
				apr_pkg::CFG_INNER: begin
					icnt_q    <= c_inner;
					icnt_m1_q <= c_inner - 11'd1;
				end
				default: ;
			endcase
			if (cfg_index == apr_pkg::CFG_OUTER || cfg_index == apr_pkg::CFG_REDUCE ||
			    cfg_index == apr_pkg::CFG_INNER) begin
				inner_q <= '0;
				axis_q  <= '0;
				outer_q <= '0;
				base_q  <= '0;
			end
		end else if (advance) begin
			// Step inner, then axis, then outer; all wrap to zero at tensor end
			if (inner_end) begin
				inner_q <= '0;
				if (axis_end) begin
					axis_q <= '0;
					if (outer_end) begin
						outer_q <= '0;
						base_q  <= '0;
					end else begin
						outer_q <= outer_q + 20'd1;
						base_q  <= base_q + 30'(icnt_q);
					end
				end else begin
					axis_q <= axis_q + 20'd1;
				end
			end else begin
				inner_q <= inner_q + AW'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/axis_product_reduction.sv */
`default_nettype none

// Channel   Handshake                 Payload
// in        in_valid / in_ready       element_value
// out       out_valid / out_ready     product_value, position_index, product_overflow,
//                                     tensor_overflow, last_of_tensor
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One word per cycle while in_ready is high. A word is read from the partial buffer at accept,
// multiplied in stage 1, written back in stage 2; same-entry hazards are forwarded.
// A result passes through stage 1 and stage 2 into the output queue before it appears on out.
// in_ready drops while queued results plus words in flight reach the 4-entry queue depth.
// Reset clears counters, configuration registers and valid bits; the buffer needs no clearing pass.

module axis_product_reduction #(
	parameter int MAX_INNER = apr_pkg::MAX_INNER_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic signed [31:0] element_value,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [31:0] product_value,
	output      logic [29:0]        position_index,
	output      logic               product_overflow,
	output      logic               tensor_overflow,
	output      logic               last_of_tensor,
	input  wire logic               cfg_valid,
	output      logic               cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam int AW = apr_pkg::addr_w(MAX_INNER);
	localparam int CW = $clog2(apr_pkg::OFIFO_DEPTH + 1);

	logic                 accept;
	logic                 cfg_wr;
	logic [AW-1:0]        seq_ip;
	apr_pkg::ctl_t        seq_ctl;
	logic [apr_pkg::MEM_W-1:0] rdata;

	// Stage 1
	logic                 v_s1;
	logic signed [31:0]   val_s1;
	logic [AW-1:0]        ip_s1;
	apr_pkg::ctl_t        ctl_s1;
	logic signed [31:0]   old_prod;
	logic                 old_ovf;
	logic signed [31:0]   mul_a;
	logic signed [63:0]   mul_s1;

	// Stage 2
	logic                 v_s2;
	logic signed [63:0]   prod_s2;
	logic                 ovfin_s2;
	logic [AW-1:0]        ip_s2;
	apr_pkg::ctl_t        ctl_s2;
	logic [31:0]          res_s2;
	logic                 ovf_s2;

	// Last write-back, missed by the read taken at the same edge
	logic                 wb_v_q;
	logic [AW-1:0]        wb_ip_q;
	logic [31:0]          wb_prod_q;
	logic                 wb_ovf_q;

	logic                 sticky_q;
	logic                 push;
	apr_pkg::out_item_t   push_item;
	apr_pkg::out_item_t   head;
	logic [CW-1:0]        fifo_cnt;
	logic [CW:0]          occupancy;

	// Admit a word only if its result is sure to find room
	assign occupancy = (CW+1)'(fifo_cnt) + (CW+1)'(v_s1) + (CW+1)'(v_s2);
	assign in_ready  = (occupancy < (CW+1)'(apr_pkg::OFIFO_DEPTH));
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	apr_seq #(.MAX_INNER(MAX_INNER)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.ip        (seq_ip),
		.ctl       (seq_ctl)
	);

	apr_mem #(.DEPTH(MAX_INNER)) u_mem (
		.clk   (clk),
		.we    (v_s2),
		.waddr (ip_s2),
		.wdata ({ovf_s2, res_s2}),
		.re    (accept),
		.raddr (seq_ip),
		.rdata (rdata)
	);

	// Pick the newest value of the entry: stage 2, then last write, then buffer
	always_comb begin
		if (v_s2 && ip_s2 == ip_s1) begin
			old_prod = $signed(res_s2);
			old_ovf  = ovf_s2;
		end else if (wb_v_q && wb_ip_q == ip_s1) begin
			old_prod = $signed(wb_prod_q);
			old_ovf  = wb_ovf_q;
		end else begin
			old_prod = $signed(rdata[31:0]);
			old_ovf  = rdata[32];
		end
	end

	// First word on the axis loads: multiply by one
	assign mul_a  = ctl_s1.first ? 32'sd1 : old_prod;
	assign mul_s1 = 64'(mul_a) * 64'(val_s1);

	// Wrap and flag overflow when the upper bits are not a sign extension
	assign res_s2 = prod_s2[31:0];
	assign ovf_s2 = ovfin_s2 | ~((&prod_s2[63:31]) | ~(|prod_s2[63:31]));

	// Advance valid bits and the write-back record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wb_v_q <= 1'b0;
		end else begin
			v_s1   <= accept;
			v_s2   <= v_s1;
			wb_v_q <= v_s2;
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1 <= element_value;
			ip_s1  <= seq_ip;
			ctl_s1 <= seq_ctl;
		end
		prod_s2   <= mul_s1;
		ovfin_s2  <= ctl_s1.first ? 1'b0 : old_ovf;
		ip_s2     <= ip_s1;
		ctl_s2    <= ctl_s1;
		wb_ip_q   <= ip_s2;
		wb_prod_q <= res_s2;
		wb_ovf_q  <= ovf_s2;
	end

	// Emit at the end of the axis
	assign push                       = v_s2 && ctl_s2.emit;
	assign push_item.product_value    = $signed(res_s2);
	assign push_item.position_index   = ctl_s2.pos;
	assign push_item.product_overflow = ovf_s2;
	assign push_item.tensor_overflow  = sticky_q | ovf_s2;
	assign push_item.last_of_tensor   = ctl_s2.last;

	// Hold the tensor-wide overflow; drop it after the last result or on a write to a known index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sticky_q <= 1'b0;
		end else if (cfg_wr && (cfg_index == apr_pkg::CFG_OUTER ||
		                        cfg_index == apr_pkg::CFG_REDUCE ||
		                        cfg_index == apr_pkg::CFG_INNER)) begin
			sticky_q <= 1'b0;
		end else if (push) begin
			sticky_q <= ctl_s2.last ? 1'b0 : (sticky_q | ovf_s2);
		end
	end

	apr_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (out_ready),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign product_value    = head.product_value;
	assign position_index   = head.position_index;
	assign product_overflow = head.product_overflow;
	assign tensor_overflow  = head.tensor_overflow;
	assign last_of_tensor   = head.last_of_tensor;

	// Admission control never lets a result meet a full queue
	a_no_fifo_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (32'(fifo_cnt) < apr_pkg::OFIFO_DEPTH || out_ready))
		else $error("output queue overflow");

	// Tensor overflow starts clear after the last result
	a_sticky_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(push && ctl_s2.last) |=> !sticky_q)
		else $error("sticky overflow not cleared at tensor end");

	// A loaded partial cannot carry overflow
	a_first_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ctl_s2.first) |-> !ovf_s2)
		else $error("overflow flagged on first element of axis");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int DEPTH = apr_pkg::MAX_INNER_DEF;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int PIPE_LATENCY = 8;
	localparam int SETTLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1750;
	localparam longint INT32_HI = 64'sd2147483647;
	localparam longint INT32_LO = -64'sd2147483648;
	localparam logic [31:0] COUNT_MASK = 32'h001F_FFFF;
	localparam logic [31:0] INNER_MASK = 32'h0000_07FF;

	typedef struct {
		bit                 is_write;
		logic [1:0]         index;
		logic [31:0]        data;
		bit                 typed;
		apr_pkg::out_item_t want;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] element_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] product_value;
	logic [29:0]        position_index;
	logic               product_overflow;
	logic               tensor_overflow;
	logic               last_of_tensor;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// Predicted block state
	logic [31:0] partial_word [DEPTH];
	logic        partial_flag [DEPTH];
	int unsigned inner_at;
	int unsigned axis_at;
	int unsigned outer_at;
	logic        sticky_flag;
	int unsigned outer_cnt;
	int unsigned reduce_len;
	int unsigned inner_cnt;

	apr_pkg::out_item_t expected_products [$];
	stim_row_t   directed_rows [$];
	int          mismatch_count = 0;
	bit          steady = 1'b0;

	axis_product_reduction #(
		.MAX_INNER(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.element_value(element_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.product_value(product_value),
		.position_index(position_index),
		.product_overflow(product_overflow),
		.tensor_overflow(tensor_overflow),
		.last_of_tensor(last_of_tensor),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic restart_tensor();
		inner_at = 0;
		axis_at = 0;
		outer_at = 0;
		sticky_flag = 1'b0;
	endtask

	// Mirror a register write; unknown indexes leave the tensor running
	task automatic apply_register(input logic [1:0] idx, input logic [31:0] data);
		case (idx)
			apr_pkg::CFG_OUTER: begin
				outer_cnt = clamp_count(int'(data[20:0]), int'(apr_pkg::AXIS_MAX));
			end
			apr_pkg::CFG_REDUCE: begin
				reduce_len = clamp_count(int'(data[20:0]), int'(apr_pkg::AXIS_MAX));
			end
			apr_pkg::CFG_INNER: begin
				inner_cnt = clamp_count(int'(data[10:0]), DEPTH);
			end
			default: begin
				return;
			end
		endcase
		restart_tensor();
	endtask

	// Fold one word into its partial product; report the product when the axis ends
	task automatic fold_element(input logic signed [31:0] v, output bit fired,
			output apr_pkg::out_item_t r);
		int unsigned slot;
		logic [31:0] prod;
		logic        flag;
		longint      full;
		bit          last;
		slot = inner_at % DEPTH;
		fired = 1'b0;
		r = '0;
		if (axis_at == 0) begin
			prod = v;
			flag = 1'b0;
		end else begin
			full = longint'($signed(partial_word[slot])) * longint'(v);
			prod = full[31:0];
			flag = partial_flag[slot] | (full > INT32_HI) | (full < INT32_LO);
		end
		partial_word[slot] = prod;
		partial_flag[slot] = flag;
		if (axis_at + 1 >= reduce_len) begin
			last = (outer_at + 1 >= outer_cnt) && (inner_at + 1 >= inner_cnt);
			sticky_flag = sticky_flag | flag;
			r.product_value = prod;
			r.position_index = 30'(longint'(outer_at) * inner_cnt + inner_at);
			r.product_overflow = flag;
			r.tensor_overflow = sticky_flag;
			r.last_of_tensor = last;
			fired = 1'b1;
			if (last) begin
				restart_tensor();
				return;
			end
		end
		// Advance inner, then axis, then outer position
		inner_at++;
		if (inner_at >= inner_cnt) begin
			inner_at = 0;
			axis_at++;
			if (axis_at >= reduce_len) begin
				axis_at = 0;
				outer_at++;
				if (outer_at >= outer_cnt)
					restart_tensor();
			end
		end
	endtask

	// Offer one word, hold it until accepted, then queue its result if any
	task automatic push_element(input logic [31:0] v, input bit typed,
			input apr_pkg::out_item_t want);
		int gap;
		bit fired;
		apr_pkg::out_item_t r;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		element_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		fold_element(v, fired, r);
		if (typed)
			expected_products = {expected_products, want};
		else if (fired)
			expected_products = {expected_products, r};
	endtask

	// Write one register and mirror it once the word is taken
	task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
		repeat (1 + $urandom_range(0, 3)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		apply_register(idx, data);
	endtask

	// Drop valid, wait out every pending result, then let the pipeline empty
	task automatic settle_block();
		int waited;
		in_valid <= 1'b0;
		waited = 0;
		while (expected_products.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_products.size() != 0) begin
			$error("%0d expected results never arrived", expected_products.size());
			mismatch_count += expected_products.size();
			expected_products.delete();
		end
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	function automatic logic [31:0] draw_element();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return r;
			1: return 32'($signed($urandom_range(0, 16)) - 8);
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h0000_0000;
					1: return 32'h0000_0001;
					2: return 32'hFFFF_FFFF;
					3: return 32'h8000_0000;
					default: return 32'h7FFF_FFFF;
				endcase
			end
			default: return {{16{r[15]}}, r[15:0]};
		endcase
	endfunction

	// Put a count in the register bits, with junk above them; a one may go in as zero
	function automatic logic [31:0] encode_count(int unsigned val, logic [31:0] mask);
		logic [31:0] junk;
		junk = $urandom & ~mask;
		if (val == 1 && $urandom_range(0, 1) == 1)
			return junk;
		return junk | val;
	endfunction

	task automatic add_element(input logic [31:0] v);
		stim_row_t row;
		row.is_write = 1'b0;
		row.index = '0;
		row.data = v;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows = {directed_rows, row};
	endtask

	task automatic add_result(input logic [31:0] v, input logic [31:0] prod,
			input logic [29:0] pos, input logic po, input logic to, input logic last);
		stim_row_t row;
		row.is_write = 1'b0;
		row.index = '0;
		row.data = v;
		row.typed = 1'b1;
		row.want.product_value = prod;
		row.want.position_index = pos;
		row.want.product_overflow = po;
		row.want.tensor_overflow = to;
		row.want.last_of_tensor = last;
		directed_rows = {directed_rows, row};
	endtask

	task automatic add_write(input logic [1:0] idx, input logic [31:0] data);
		stim_row_t row;
		row.is_write = 1'b1;
		row.index = idx;
		row.data = data;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows = {directed_rows, row};
	endtask

	// Drain results with random stalls and compare each against the oldest prediction
	initial begin : result_sink
		int stall;
		apr_pkg::out_item_t want;
		wait (arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (expected_products.size() == 0) begin
				$error("unexpected result word: product_value %h position_index %0d",
					product_value, position_index);
				mismatch_count++;
			end else begin
				want = expected_products.pop_front();
				if (product_value !== want.product_value) begin
					$error("product_value: expected %h, got %h",
						want.product_value, product_value);
					mismatch_count++;
				end
				if (position_index !== want.position_index) begin
					$error("position_index: expected %0d, got %0d",
						want.position_index, position_index);
					mismatch_count++;
				end
				if (product_overflow !== want.product_overflow) begin
					$error("product_overflow: expected %b, got %b",
						want.product_overflow, product_overflow);
					mismatch_count++;
				end
				if (tensor_overflow !== want.tensor_overflow) begin
					$error("tensor_overflow: expected %b, got %b",
						want.tensor_overflow, tensor_overflow);
					mismatch_count++;
				end
				if (last_of_tensor !== want.last_of_tensor) begin
					$error("last_of_tensor: expected %b, got %b",
						want.last_of_tensor, last_of_tensor);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : run_limit
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int random_items;
		bit first_phase;
		int unsigned want_outer;
		int unsigned want_reduce;
		int unsigned want_inner;
		int unsigned val;
		int unsigned tensor_words;
		int unsigned words;
		int pause_at;
		int tensors;
		int rot;
		logic [1:0] idx;

		outer_cnt = 1;
		reduce_len = 1;
		inner_cnt = 1;
		restart_tensor();
		for (int i = 0; i < DEPTH; i++) begin
			partial_word[i] = '0;
			partial_flag[i] = 1'b0;
		end

		// Directed rows: reset shape, sign extremes, overflow, shape changes
		add_result(32'h7FFF_FFFF, 32'h7FFF_FFFF, 30'd0, 1'b0, 1'b0, 1'b1);
		add_result(32'h8000_0000, 32'h8000_0000, 30'd0, 1'b0, 1'b0, 1'b1);
		add_result(32'h0000_0000, 32'h0000_0000, 30'd0, 1'b0, 1'b0, 1'b1);
		add_write(apr_pkg::CFG_REDUCE, 32'd2);
		add_element(32'h8000_0000);
		add_result(32'hFFFF_FFFF, 32'h8000_0000, 30'd0, 1'b1, 1'b1, 1'b1);
		add_element(32'h7FFF_FFFF);
		add_result(32'h7FFF_FFFF, 32'h0000_0001, 30'd0, 1'b1, 1'b1, 1'b1);
		add_element(32'd3);
		add_result(32'd5, 32'd15, 30'd0, 1'b0, 1'b0, 1'b1);
		// Zero count acts as one; junk above the inner bits is dropped
		add_write(apr_pkg::CFG_OUTER, 32'd0);
		add_write(apr_pkg::CFG_INNER, 32'hFFFF_F803);
		add_element(32'd2);
		add_element(32'hFFFF_FFFD);
		add_element(32'h0001_0000);
		add_element(32'd7);
		add_element(32'd4);
		add_element(32'h0001_0000);
		// Abandon a tensor halfway with a register write
		add_element(32'd9);
		add_element(32'd11);
		add_write(apr_pkg::CFG_REDUCE, 32'd0);
		add_result(32'd5, 32'd5, 30'd0, 1'b0, 1'b0, 1'b0);
		// Unknown index leaves the tensor running
		add_write(CFG_UNUSED, 32'hFFFF_FFFF);
		add_result(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30'd1, 1'b0, 1'b0, 1'b0);
		add_result(32'd6, 32'd6, 30'd2, 1'b0, 1'b0, 1'b1);
		// Saturate outer and inner counts
		add_write(apr_pkg::CFG_OUTER, 32'h001F_FFFF);
		add_write(apr_pkg::CFG_INNER, 32'h0000_07FF);
		add_element(32'd1);
		add_element(32'd2);
		add_write(apr_pkg::CFG_REDUCE, 32'h0010_0000);
		add_element(32'd4);
		add_element(32'd5);

		// Hold reset, then release on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				settle_block();
				write_register(directed_rows[i].index, directed_rows[i].data);
			end else begin
				push_element(directed_rows[i].data, directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		// Random phases: new shape each time, mostly whole tensors
		random_items = 0;
		first_phase = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			settle_block();
			steady = ($urandom_range(0, 3) == 0);
			if (first_phase) begin
				want_outer = 1;
				want_reduce = 2;
				want_inner = $urandom_range(512, 800);
				first_phase = 1'b0;
			end else begin
				want_outer = $urandom_range(1, 4);
				want_reduce = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
					: $urandom_range(1, 6);
				want_inner = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40)
					: $urandom_range(1, 8);
			end
			rot = $urandom_range(0, 2);
			for (int k = 0; k < 3; k++) begin
				idx = 2'((rot + k) % 3);
				case (idx)
					apr_pkg::CFG_OUTER: val = want_outer;
					apr_pkg::CFG_REDUCE: val = want_reduce;
					default: val = want_inner;
				endcase
				if ($urandom_range(0, 3) == 0)
					write_register(idx, $urandom);
				write_register(idx, encode_count(val,
					(idx == apr_pkg::CFG_INNER) ? INNER_MASK : COUNT_MASK));
			end
			tensor_words = outer_cnt * reduce_len * inner_cnt;
			tensors = $urandom_range(1, 3);
			for (int t = 0; t < tensors; t++) begin
				words = tensor_words;
				if (t == tensors - 1 && tensor_words > 1 && $urandom_range(0, 4) == 0)
					words = $urandom_range(1, tensor_words - 1);
				pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, words - 1) : -1;
				for (int n = 0; n < words && random_items < RANDOM_ITEMS; n++) begin
					if (n == pause_at) begin
						settle_block();
						write_register(CFG_UNUSED, $urandom);
					end
					push_element(draw_element(), 1'b0, '0);
					random_items++;
				end
			end
		end

		settle_block();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
